/* design/bnb_pkg.sv */
// Package for the background neighbour blackening core: pixel word type,
// register indexes, item codes and reset values.
// Depends on nothing; every other file of the core but bnb_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package bnb_pkg;

	localparam int COLOR_W = 8;
	localparam int CFG_IW  = 3;
	localparam int CFG_DW  = 12;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;

	localparam logic [CFG_IW-1:0] REG_BG_BLUE      = 3'd0;
	localparam logic [CFG_IW-1:0] REG_BG_GREEN     = 3'd1;
	localparam logic [CFG_IW-1:0] REG_BG_RED       = 3'd2;
	localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 3'd4;

	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	localparam logic [COLOR_W-1:0] BG_RESET     = 8'd255;
	localparam logic [CFG_DW-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [CFG_DW-1:0]  HEIGHT_RESET = 12'd480;

	typedef struct packed {
		logic [COLOR_W-1:0] alpha;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} pixel_t;

endpackage

`default_nettype wire

/* design/bnb_if.sv */
// Stream interfaces of the core: the input pixel channel and the result channel.
// Depends on bnb_pkg for the channel widths.
`timescale 1ns / 1ps
`default_nettype none

interface bnb_in_if import bnb_pkg::*;;
	logic               valid;
	logic               ready;
	logic               func;
	logic [COLOR_W-1:0] in_blue;
	logic [COLOR_W-1:0] in_green;
	logic [COLOR_W-1:0] in_red;
	logic [COLOR_W-1:0] in_alpha;

	modport source (output valid, func, in_blue, in_green, in_red, in_alpha, input ready);
	modport sink (input valid, func, in_blue, in_green, in_red, in_alpha, output ready);
endinterface

interface bnb_out_if import bnb_pkg::*;;
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] out_blue;
	logic [COLOR_W-1:0] out_green;
	logic [COLOR_W-1:0] out_red;
	logic [COLOR_W-1:0] out_alpha;
	logic               frame_end;

	modport source (output valid, out_blue, out_green, out_red, out_alpha, frame_end,
		input ready);
	modport sink (input valid, out_blue, out_green, out_red, out_alpha, frame_end,
		output ready);
endinterface

`default_nettype wire

/* design/bnb_ram.sv */
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bnb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/background_neighbour_blackening_core.sv */
// Top level of the background neighbour blackening core: line buffers, judging stage
// and output register. Depends on bnb_pkg, bnb_if and bnb_ram.
//
//   channel   | direction | carries
//   ----------+-----------+-------------------------------------------------
//   pix_in    | in        | func, in_blue, in_green, in_red, in_alpha
//   pix_out   | out       | out_blue, out_green, out_red, out_alpha, frame_end
//   cfg_*     | in        | cfg_we, cfg_index, cfg_data (write only)
//
// One word is accepted every cycle while pix_out does not stall; the line buffer reads are registered
// into the judge stage, whose combinational judging logic feeds the output register.
// Reset clears the configuration registers, counters and both pipeline valid bits; the line buffers are not cleared.
// A stall on pix_out holds the result, and pix_in.ready drops only when the judge stage is also full.
`timescale 1ns / 1ps
`default_nettype none

module background_neighbour_blackening_core import bnb_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	bnb_in_if.sink                 pix_in,
	bnb_out_if.source              pix_out,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data
);

	localparam int IW  = $clog2(MAX_WIDTH);
	localparam int CW  = $clog2(MAX_WIDTH + 1);
	localparam int RW  = $clog2(MAX_HEIGHT + 1);
	localparam int WXW = (CW > CFG_DW) ? CW : CFG_DW;
	localparam int HXW = (RW > CFG_DW) ? RW : CFG_DW;
	localparam int PW  = $bits(pixel_t);

	logic [COLOR_W-1:0] bg_blue_q, bg_green_q, bg_red_q;
	logic [CFG_DW-1:0]  frame_width_q, frame_height_q;
	logic [IW-1:0]      col_q, drain_q;
	logic [RW-1:0]      row_q;

	logic [WXW-1:0] width_x;
	logic [HXW-1:0] height_x;
	logic [CW-1:0]  w_eff;
	logic [RW-1:0]  h_eff;

	logic          accept, is_pix, draining, geom_wr;
	logic [IW-1:0] pix_col, drn_col, cur_col;
	logic [CW-1:0] col_inc;
	logic          col_last, judge_new, above_ok_new, below_bg_new, store_we;
	pixel_t        in_pix;

	logic          valid_s1, first_s1, right_ok_s1, above_ok_s1, below_bg_s1, last_s1;
	logic          fwd_s1, fwd_flag_s1;
	logic [IW-1:0] col_s1;
	logic [PW-1:0] cur_rd_s1, nxt_rd_s1;
	logic          flag_rd_s1;

	pixel_t cur_pix, nxt_pix, res_pix;
	logic   conv, seen, above_flag, flag_s1, out_free, advance, last_flag_q;

	pixel_t out_pix_q;
	logic   out_end_q, out_valid_q;

	function automatic logic is_bg(pixel_t p, logic [COLOR_W-1:0] b, logic [COLOR_W-1:0] g,
		logic [COLOR_W-1:0] r);
		return (p.blue == b) && (p.green == g) && (p.red == r);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_blue_q      <= BG_RESET;
			bg_green_q     <= BG_RESET;
			bg_red_q       <= BG_RESET;
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BG_BLUE:      bg_blue_q      <= cfg_data[COLOR_W-1:0];
				REG_BG_GREEN:     bg_green_q     <= cfg_data[COLOR_W-1:0];
				REG_BG_RED:       bg_red_q       <= cfg_data[COLOR_W-1:0];
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Geometry is clamped to 1..MAX_WIDTH columns and 1..MAX_HEIGHT rows; the line buffers hold MAX_WIDTH words.
	always_comb begin
		width_x  = WXW'(frame_width_q);
		height_x = HXW'(frame_height_q);
		if (width_x == '0) begin
			w_eff = CW'(1);
		end else if (width_x > WXW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(width_x);
		end
		if (height_x == '0) begin
			h_eff = RW'(1);
		end else if (height_x > HXW'(MAX_HEIGHT)) begin
			h_eff = RW'(MAX_HEIGHT);
		end else begin
			h_eff = RW'(height_x);
		end
	end

	assign in_pix.blue  = pix_in.in_blue;
	assign in_pix.green = pix_in.in_green;
	assign in_pix.red   = pix_in.in_red;
	assign in_pix.alpha = pix_in.in_alpha;

	assign accept   = pix_in.valid && pix_in.ready;
	assign is_pix   = (pix_in.func == FUNC_PIXEL);
	assign draining = (row_q >= h_eff);
	assign geom_wr  = cfg_we && ((cfg_index == REG_FRAME_WIDTH) ||
		(cfg_index == REG_FRAME_HEIGHT));

	always_comb begin
		pix_col = (CW'(col_q) >= w_eff) ? '0 : col_q;
		drn_col = (CW'(drain_q) >= w_eff) ? IW'(w_eff - CW'(1)) : drain_q;
		cur_col = is_pix ? pix_col : drn_col;
		col_inc = CW'(cur_col) + CW'(1);
		col_last = (col_inc >= w_eff);
		if (is_pix) begin
			judge_new    = !draining && (row_q != '0);
			above_ok_new = (row_q > RW'(1));
			below_bg_new = is_bg(in_pix, bg_blue_q, bg_green_q, bg_red_q);
		end else begin
			judge_new    = draining;
			above_ok_new = (h_eff > RW'(1));
			below_bg_new = 1'b0;
		end
		store_we = accept && is_pix && !draining;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else if (geom_wr) begin
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else if (accept) begin
			if (is_pix && !draining) begin
				if (col_last) begin
					col_q   <= '0;
					row_q   <= row_q + RW'(1);
					drain_q <= '0;
				end else begin
					col_q <= IW'(col_inc);
				end
			end else if (!is_pix && draining) begin
				if (col_last) begin
					col_q   <= '0;
					row_q   <= '0;
					drain_q <= '0;
				end else begin
					drain_q <= IW'(col_inc);
				end
			end
		end
	end

	bnb_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_row_cur (
		.clk  (clk),
		.we   (store_we),
		.waddr(pix_col),
		.wdata(in_pix),
		.re   (accept),
		.raddr(cur_col),
		.rdata(cur_rd_s1)
	);

	bnb_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_row_nxt (
		.clk  (clk),
		.we   (store_we),
		.waddr(pix_col),
		.wdata(in_pix),
		.re   (accept),
		.raddr(IW'(col_inc)),
		.rdata(nxt_rd_s1)
	);

	bnb_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_flag (
		.clk  (clk),
		.we   (advance),
		.waddr(col_s1),
		.wdata(flag_s1),
		.re   (accept),
		.raddr(cur_col),
		.rdata(flag_rd_s1)
	);

	// The left neighbour is always the previous judged pixel, so its flag sits in a register.
	always_comb begin
		cur_pix    = pixel_t'(cur_rd_s1);
		nxt_pix    = pixel_t'(nxt_rd_s1);
		above_flag = fwd_s1 ? fwd_flag_s1 : flag_rd_s1;
		conv = (cur_pix.blue != bg_blue_q) && (cur_pix.green != bg_green_q) &&
			(cur_pix.red != bg_red_q);
		seen = (right_ok_s1 && is_bg(nxt_pix, bg_blue_q, bg_green_q, bg_red_q)) ||
			(!first_s1 && last_flag_q) || below_bg_s1 || (above_ok_s1 && above_flag);
		res_pix = cur_pix;
		if (conv && !seen) begin
			res_pix.blue  = '0;
			res_pix.green = '0;
			res_pix.red   = '0;
		end
		flag_s1 = is_bg(res_pix, bg_blue_q, bg_green_q, bg_red_q);
	end

	assign out_free     = !out_valid_q || pix_out.ready;
	assign advance      = valid_s1 && out_free;
	assign pix_in.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= judge_new;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// The flag of the word leaving the judge stage is written in the same edge it is read.
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= cur_col;
			first_s1    <= (cur_col == '0);
			right_ok_s1 <= !col_last;
			above_ok_s1 <= above_ok_new;
			below_bg_s1 <= below_bg_new;
			last_s1     <= !is_pix && col_last;
			fwd_s1      <= valid_s1 && (col_s1 == cur_col);
			fwd_flag_s1 <= flag_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_flag_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				last_flag_q <= flag_s1;
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_pix_q <= res_pix;
			out_end_q <= last_s1;
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.out_blue  = out_pix_q.blue;
	assign pix_out.out_green = out_pix_q.green;
	assign pix_out.out_red   = out_pix_q.red;
	assign pix_out.out_alpha = out_pix_q.alpha;
	assign pix_out.frame_end = out_end_q;

endmodule

`default_nettype wire

/* design/bnb_checker.sv */
// Port level checker for the background neighbour blackening core, with its bind.
// Depends on bnb_pkg and on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module bnb_checker import bnb_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [32:0] out_word
);

	logic accepted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			accepted_q <= 1'b1;
		end
	end

	a_idle_in_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("Result word shown during reset.");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("Input stalled while the output side was free.");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> accepted_q)
		else $error("Result word without any accepted input word.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
		else $error("Stalled result word changed or vanished.");

endmodule

bind background_neighbour_blackening_core bnb_checker u_bnb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (pix_in.valid),
	.in_ready (pix_in.ready),
	.out_valid(pix_out.valid),
	.out_ready(pix_out.ready),
	.out_word ({pix_out.frame_end, pix_out.out_alpha, pix_out.out_red,
		pix_out.out_green, pix_out.out_blue})
);

`default_nettype wire

/* tb/sv/background_neighbour_blackening_core_tb.sv */
// Self-checking testbench for the background neighbour blackening core: directed frames,
// output back-pressure and random frames against an in-bench predictor.
// Depends on bnb_pkg, bnb_if and the core itself.
`timescale 1ns / 1ps

module background_neighbour_blackening_core_tb;
	import bnb_pkg::*;

	localparam int RANDOM_WORDS = 1000;
	localparam int CALM_TAIL    = 150;
	localparam int QUIET_CYCLES = 20;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 1500000;

	typedef struct packed {
		pixel_t pix;
		logic   frame_end;
	} out_word_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	bnb_in_if  pix_in();
	bnb_out_if pix_out();

	background_neighbour_blackening_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in),
		.pix_out   (pix_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [COLOR_W-1:0] bg_b = BG_RESET;
	logic [COLOR_W-1:0] bg_g = BG_RESET;
	logic [COLOR_W-1:0] bg_r = BG_RESET;
	logic [CFG_DW-1:0]  frame_w = WIDTH_RESET;
	logic [CFG_DW-1:0]  frame_h = HEIGHT_RESET;
	pixel_t             held_row [MAX_WIDTH_DEF];
	bit                 bg_flag [MAX_WIDTH_DEF];
	int unsigned        col_pos = 0;
	int unsigned        row_pos = 0;
	int unsigned        drain_pos = 0;

	out_word_t   delayed_pixels[$];
	out_word_t   head_word;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_request = 0;
	bit          idle_on = 1'b1;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int unsigned used_width();
		if (frame_w == 0) return 1;
		if (frame_w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
		return 32'(frame_w);
	endfunction

	function automatic int unsigned used_height();
		if (frame_h == 0) return 1;
		if (frame_h > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
		return 32'(frame_h);
	endfunction

	function automatic bit matches_bg(pixel_t p);
		return p.blue == bg_b && p.green == bg_g && p.red == bg_r;
	endfunction

	// A pixel differing from the background in every channel turns black unless one of
	// its in-frame neighbours is exactly the background colour.
	function automatic pixel_t judge_pixel(int unsigned c, int unsigned rr, bit has_below,
		pixel_t below, int unsigned w);
		pixel_t p;
		bit     blacken;
		bit     near_bg;
		p = held_row[c];
		blacken = p.blue != bg_b && p.green != bg_g && p.red != bg_r;
		if (blacken) begin
			near_bg = 1'b0;
			if (c + 1 < w && matches_bg(held_row[c + 1])) near_bg = 1'b1;
			if (c > 0 && bg_flag[c - 1]) near_bg = 1'b1;
			if (has_below && matches_bg(below)) near_bg = 1'b1;
			if (rr > 0 && bg_flag[c]) near_bg = 1'b1;
			blacken = !near_bg;
		end
		if (blacken) begin
			p.blue = '0;
			p.green = '0;
			p.red = '0;
		end
		bg_flag[c] = matches_bg(p);
		return p;
	endfunction

	function automatic void advance_frame_model(logic func, pixel_t pix);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		out_word_t   res;
		w = used_width();
		h = used_height();
		res.frame_end = 1'b0;
		if (func == FUNC_PIXEL) begin
			if (row_pos < h) begin
				c = (col_pos >= w) ? 0 : col_pos;
				if (row_pos > 0) begin
					res.pix = judge_pixel(c, row_pos - 1, 1'b1, pix, w);
					delayed_pixels.push_back(res);
				end
				held_row[c] = pix;
				c++;
				if (c >= w) begin
					c = 0;
					row_pos++;
					drain_pos = 0;
				end
				col_pos = c;
			end
		end else if (row_pos >= h) begin
			c = (drain_pos >= w) ? w - 1 : drain_pos;
			res.pix = judge_pixel(c, h - 1, 1'b0, '0, w);
			res.frame_end = (c + 1 >= w);
			delayed_pixels.push_back(res);
			if (res.frame_end) begin
				col_pos = 0;
				row_pos = 0;
				drain_pos = 0;
			end else begin
				drain_pos = c + 1;
			end
		end
	endfunction

	function automatic void check_field(string name, logic [COLOR_W-1:0] want,
		logic [COLOR_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
			if (delayed_pixels.size() == 0) begin
				$error("unexpected word: blue %0h green %0h red %0h alpha %0h",
					pix_out.out_blue, pix_out.out_green, pix_out.out_red, pix_out.out_alpha);
				mismatch_count++;
			end else begin
				head_word = delayed_pixels.pop_front();
				check_field("out_blue", head_word.pix.blue, pix_out.out_blue);
				check_field("out_green", head_word.pix.green, pix_out.out_green);
				check_field("out_red", head_word.pix.red, pix_out.out_red);
				check_field("out_alpha", head_word.pix.alpha, pix_out.out_alpha);
				check_field("frame_end", COLOR_W'(head_word.frame_end),
					COLOR_W'(pix_out.frame_end));
			end
		end
	end

	initial begin
		int unsigned held;
		pix_out.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request != 0) begin
				pix_out.ready <= 1'b0;
				held = 0;
				while (held < hold_request) begin
					@(posedge clk);
					held++;
				end
				hold_request = 0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				pix_out.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			pix_out.ready <= 1'b1;
			@(posedge clk);
		end
	end

	function automatic pixel_t mk_pix(logic [7:0] b, logic [7:0] g, logic [7:0] r,
		logic [7:0] a);
		pixel_t p;
		p.blue = b;
		p.green = g;
		p.red = r;
		p.alpha = a;
		return p;
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				p.blue = bg_b;
				p.green = bg_g;
				p.red = bg_r;
			end
			4: p.blue = bg_b;
			5: begin
				p.green = bg_g;
				p.red = bg_r;
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic send_word(logic func, pixel_t pix);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			pix_in.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.func <= func;
		pix_in.in_blue <= pix.blue;
		pix_in.in_green <= pix.green;
		pix_in.in_red <= pix.red;
		pix_in.in_alpha <= pix.alpha;
		do @(posedge clk); while (pix_in.ready !== 1'b1);
		advance_frame_model(func, pix);
	endtask

	task automatic wait_quiet();
		pix_in.valid <= 1'b0;
		while (delayed_pixels.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_BG_BLUE: bg_b = value[COLOR_W-1:0];
			REG_BG_GREEN: bg_g = value[COLOR_W-1:0];
			REG_BG_RED: bg_r = value[COLOR_W-1:0];
			REG_FRAME_WIDTH, REG_FRAME_HEIGHT: begin
				if (idx == REG_FRAME_WIDTH) frame_w = value;
				else frame_h = value;
				col_pos = 0;
				row_pos = 0;
				drain_pos = 0;
			end
			default: ;
		endcase
	endtask

	task automatic write_geometry(int unsigned w, int unsigned h);
		write_reg(REG_FRAME_WIDTH, CFG_DW'(w));
		write_reg(REG_FRAME_HEIGHT, CFG_DW'(h));
	endtask

	task automatic write_random_colour();
		logic [CFG_IW-1:0]  idx;
		logic [COLOR_W-1:0] value;
		idx = CFG_IW'($urandom_range(REG_BG_BLUE, REG_BG_RED));
		case ($urandom_range(0, 3))
			0: value = '0;
			1: value = '1;
			default: value = COLOR_W'($urandom);
		endcase
		write_reg(idx, CFG_DW'(value));
	endtask

	// With the reset geometry every word here lies in the first row, so nothing comes out.
	task automatic test_reset_values();
		send_word(FUNC_PIXEL, mk_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_word(FUNC_PIXEL, mk_pix(8'h00, 8'h00, 8'h00, 8'h00));
		send_word(FUNC_DRAIN, mk_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_word(FUNC_PIXEL, mk_pix(8'h5A, 8'hA5, 8'h3C, 8'hC3));
		wait_quiet();
	endtask

	task automatic test_neighbourhood();
		pixel_t bg;
		write_reg(REG_BG_BLUE, 12'h000);
		write_reg(REG_BG_GREEN, 12'h0FF);
		write_reg(REG_BG_RED, 12'h05A);
		write_geometry(3, 3);
		bg = mk_pix(8'h00, 8'hFF, 8'h5A, 8'hFF);
		send_word(FUNC_PIXEL, bg);
		send_word(FUNC_PIXEL, mk_pix(8'hFF, 8'h00, 8'hA5, 8'h00));
		send_word(FUNC_PIXEL, mk_pix(8'h12, 8'h34, 8'h56, 8'hFF));
		send_word(FUNC_PIXEL, mk_pix(8'hFF, 8'h00, 8'hFF, 8'h80));
		send_word(FUNC_DRAIN, mk_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_word(FUNC_PIXEL, mk_pix(8'h80, 8'h80, 8'h80, 8'h7F));
		send_word(FUNC_PIXEL, mk_pix(8'h00, 8'h11, 8'h22, 8'h33));
		send_word(FUNC_PIXEL, mk_pix(8'h01, 8'hFE, 8'h5B, 8'hC0));
		send_word(FUNC_PIXEL, mk_pix(8'h00, 8'hFF, 8'h5A, 8'h01));
		send_word(FUNC_PIXEL, mk_pix(8'hAA, 8'h55, 8'hAA, 8'h55));
		send_word(FUNC_DRAIN, '0);
		send_word(FUNC_PIXEL, mk_pix(8'h77, 8'h77, 8'h77, 8'h77));
		send_word(FUNC_DRAIN, '1);
		send_word(FUNC_DRAIN, '0);
		wait_quiet();
	endtask

	task automatic test_geometry_abandon();
		write_geometry(3, 3);
		repeat (4) send_word(FUNC_PIXEL, rand_pixel());
		wait_quiet();
		write_geometry(2, 2);
		repeat (4) send_word(FUNC_PIXEL, rand_pixel());
		repeat (2) send_word(FUNC_DRAIN, rand_pixel());
		wait_quiet();
	endtask

	task automatic test_single_pixel_frame();
		write_reg(REG_FRAME_WIDTH, '0);
		write_reg(REG_FRAME_HEIGHT, '0);
		send_word(FUNC_PIXEL, rand_pixel());
		send_word(FUNC_PIXEL, rand_pixel());
		send_word(FUNC_DRAIN, rand_pixel());
		send_word(FUNC_DRAIN, rand_pixel());
		wait_quiet();
	endtask

	task automatic test_unknown_register();
		for (int i = REG_FRAME_HEIGHT + 1; i < (1 << CFG_IW); i++) write_reg(CFG_IW'(i), '1);
		send_word(FUNC_PIXEL, rand_pixel());
		send_word(FUNC_DRAIN, rand_pixel());
		wait_quiet();
	endtask

	task automatic test_output_hold_off();
		write_geometry(8, 8);
		idle_on = 1'b0;
		hold_request = HOLD_CYCLES;
		repeat (64) send_word(FUNC_PIXEL, rand_pixel());
		repeat (8) send_word(FUNC_DRAIN, rand_pixel());
		wait_quiet();
		idle_on = 1'b1;
	endtask

	task automatic test_random_frames();
		int unsigned sent;
		int unsigned w;
		int unsigned h;
		int unsigned stop_at;
		bit          reset_geometry;
		sent = 0;
		reset_geometry = 1'b1;
		while (sent < RANDOM_WORDS) begin
			idle_on = (sent + CALM_TAIL >= RANDOM_WORDS) ? 1'b0 : ($urandom_range(0, 3) != 0);
			wait_quiet();
			if (reset_geometry || $urandom_range(0, 2) != 0) begin
				w = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
				h = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
				write_geometry(w, h);
			end
			if ($urandom_range(0, 2) == 0) write_random_colour();
			w = used_width();
			h = used_height();
			stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, w * h - 1) : w * h;
			reset_geometry = (stop_at < w * h);
			for (int i = 0; i < stop_at; i++) begin
				if (sent + CALM_TAIL >= RANDOM_WORDS) idle_on = 1'b0;
				if ($urandom_range(0, 39) == 0) send_word(FUNC_DRAIN, rand_pixel());
				if ($urandom_range(0, 59) == 0) begin
					wait_quiet();
					write_random_colour();
				end
				send_word(FUNC_PIXEL, rand_pixel());
				sent++;
			end
			if (!reset_geometry) begin
				for (int i = 0; i < w; i++) begin
					if (sent + CALM_TAIL >= RANDOM_WORDS) idle_on = 1'b0;
					if ($urandom_range(0, 19) == 0) send_word(FUNC_PIXEL, rand_pixel());
					send_word(FUNC_DRAIN, rand_pixel());
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		pix_in.valid <= 1'b0;
		pix_in.func <= FUNC_PIXEL;
		pix_in.in_blue <= '0;
		pix_in.in_green <= '0;
		pix_in.in_red <= '0;
		pix_in.in_alpha <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_neighbourhood();
		test_geometry_abandon();
		test_single_pixel_frame();
		test_unknown_register();
		test_output_hold_off();
		test_random_frames();
		wait_quiet();
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
